@@ rtl/markov_chain_n_step_probability_assert.svh @@
// ---------------------------------------------------------------------------
// markov chain n-step probability assertion macros
// shared concurrent check forms, clocked on clk, disabled while in reset
// ---------------------------------------------------------------------------
`ifndef MARKOV_CHAIN_N_STEP_PROBABILITY_ASSERT_SVH
`define MARKOV_CHAIN_N_STEP_PROBABILITY_ASSERT_SVH

// same-cycle implication
`define MCNSP_ASSERT_IMPLY(label, ant, con) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error("mcnsp check failed");

// next-cycle implication
`define MCNSP_ASSERT_NEXT(label, ant, con) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
        else $error("mcnsp check failed");

`endif

@@ rtl/mcnsp_pkg.sv @@
// ---------------------------------------------------------------------------
// mcnsp_pkg
// types and constants of the markov chain n-step probability block
// ---------------------------------------------------------------------------
package mcnsp_pkg;

    localparam int VAL_W  = 17;
    localparam int FRAC_W = 16;
    localparam logic [VAL_W-1:0] VAL_MAX = 17'h1FFFF;

    // command codes
    localparam logic [1:0] CMD_LOAD_MATRIX = 2'd0;
    localparam logic [1:0] CMD_LOAD_VECTOR = 2'd1;
    localparam logic [1:0] CMD_RUN         = 2'd2;

    // register indexes
    localparam logic [1:0] REG_STATE_COUNT = 2'd0;
    localparam logic [1:0] REG_STEP_COUNT  = 2'd1;
    localparam logic [1:0] REG_QUERY_STATE = 2'd2;

    // matrix banks in the work ram, bank 0 holds the loaded transition matrix
    localparam logic [1:0] BANK_TRANS = 2'd0;
    localparam logic [1:0] BANK_ONE   = 2'd1;
    localparam logic [1:0] BANK_TWO   = 2'd2;
    localparam logic [1:0] BANK_THREE = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_SHIFT,
        ST_WAIT,
        ST_FIN,
        ST_FWAIT,
        ST_DONE
    } state_t;

endpackage

@@ rtl/mcnsp_ram.sv @@
// ---------------------------------------------------------------------------
// mcnsp_ram
// generic ram, one write port, two read ports with registered read data
// ---------------------------------------------------------------------------
module mcnsp_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

@@ rtl/markov_chain_n_step_probability.sv @@
// ---------------------------------------------------------------------------
// markov_chain_n_step_probability
// n-step state probability of a markov chain by matrix square-and-multiply
// ---------------------------------------------------------------------------
//  channel   direction  handshake              word
//  in        input      in_valid / in_stall    command, row_index, col_index, entry_value
//  out       output     out_valid / out_stall  probability
//  cfg       input      cfg_we                 cfg_index, cfg_data
//
//  loads write their store when accepted; a run does at most 2 * (L - 1)
//  matrix products, where L is the bit length of step_count, and then a
//  final pass with the start vector; zero steps or a query past the states
//  in use skip the final pass
//  all products use the single multiply-accumulate unit and its work ram
//  in_stall is high for the whole run; a run waits to finish while an
//  earlier word is still stalled at out
//  async active-low reset clears control state; matrix and vector stores are
//  undefined until loaded
// ---------------------------------------------------------------------------
module markov_chain_n_step_probability
    import mcnsp_pkg::*;
#(
    parameter int MAX_STATES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // input words
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [2:0]  row_index,
    input  logic [2:0]  col_index,
    input  logic [16:0] entry_value,
    // result words
    output logic        out_valid,
    input  logic        out_stall,
    output logic [16:0] probability
);

`include "markov_chain_n_step_probability_assert.svh"

    localparam int IW    = $clog2(MAX_STATES);
    localparam int AW    = 2 * IW + 2;
    localparam int DEPTH = 1 << AW;

    // configuration registers
    logic [3:0]  state_count_reg;
    logic [15:0] step_count_reg;
    logic [2:0]  query_state_reg;

    // control
    state_t         state_reg, state_next;
    logic [15:0]    e_reg;
    logic [IW-1:0]  n_m1_reg;
    logic           acc_id_reg;
    logic [1:0]     acc_bank_reg, sq_bank_reg;
    logic           kind_sq_reg;

    // operation generator
    logic           gen_active_reg;
    logic [IW-1:0]  i_reg, j_reg, k_reg;
    logic [1:0]     a_bank_reg, b_bank_reg, dst_bank_reg;
    logic           op_final_reg;

    // pipeline
    logic           s1_valid_reg, s1_first_reg, s1_last_reg;
    logic [IW-1:0]  s1_i_reg, s1_j_reg;
    logic [16:0]    s1_vec_reg;
    logic           s2_valid_reg, s2_first_reg, s2_last_reg;
    logic [IW-1:0]  s2_i_reg, s2_j_reg;
    logic [17:0]    prod_reg;
    logic [16:0]    macc_reg;

    logic [16:0]    result_reg;
    logic           out_valid_reg;
    logic [16:0]    prob_reg;

    logic [16:0]    vec_reg [MAX_STATES];

    // comb control
    logic           start_op;
    logic [1:0]     op_a_bank, op_b_bank, free_bank;
    logic           op_final;
    logic           in_accept;
    logic           pipe_empty;
    logic           q_out_of_range;
    logic [IW-1:0]  q_idx, lim;
    logic [18:0]    sum;
    logic [16:0]    sum_sat;
    logic [16:0]    opa;

    // ram ports
    logic           ram_we;
    logic [AW-1:0]  ram_waddr, ram_raddr_a, ram_raddr_b;
    logic [16:0]    ram_wdata, ram_rdata_a, ram_rdata_b;
    logic           load_matrix;

    assign in_stall    = (state_reg != ST_IDLE);
    assign in_accept   = in_valid && !in_stall;
    assign out_valid   = out_valid_reg;
    assign probability = prob_reg;

    assign pipe_empty     = !gen_active_reg && !s1_valid_reg && !s2_valid_reg;
    assign q_out_of_range = (32'(query_state_reg) > 32'(n_m1_reg));
    assign q_idx          = IW'(query_state_reg);
    assign lim            = op_final_reg ? '0 : n_m1_reg;

    // a bank that holds neither live matrix, never the loaded one
    always_comb
    begin
        if (acc_bank_reg != BANK_ONE && sq_bank_reg != BANK_ONE)
        begin
            free_bank = BANK_ONE;
        end
        else if (acc_bank_reg != BANK_TWO && sq_bank_reg != BANK_TWO)
        begin
            free_bank = BANK_TWO;
        end
        else
        begin
            free_bank = BANK_THREE;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        start_op   = 1'b0;
        op_a_bank  = acc_bank_reg;
        op_b_bank  = sq_bank_reg;
        op_final   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && command == CMD_RUN)
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (e_reg == '0)
                begin
                    state_next = ST_FIN;
                end
                else if (e_reg[0] && !acc_id_reg)
                begin
                    start_op   = 1'b1;
                    state_next = ST_WAIT;
                end
                else
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                if ((e_reg >> 1) != '0)
                begin
                    start_op   = 1'b1;
                    op_a_bank  = sq_bank_reg;
                    state_next = ST_WAIT;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_WAIT:
            begin
                if (pipe_empty)
                begin
                    state_next = kind_sq_reg ? ST_STEP : ST_SHIFT;
                end
            end
            ST_FIN:
            begin
                if (q_out_of_range || acc_id_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    start_op   = 1'b1;
                    op_b_bank  = acc_bank_reg;
                    op_final   = 1'b1;
                    state_next = ST_FWAIT;
                end
            end
            ST_FWAIT:
            begin
                if (s2_valid_reg && s2_last_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_count_reg <= 4'd8;
            step_count_reg  <= 16'd1;
            query_state_reg <= 3'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_STATE_COUNT: state_count_reg <= cfg_data[3:0];
                REG_STEP_COUNT:  step_count_reg  <= cfg_data;
                REG_QUERY_STATE: query_state_reg <= cfg_data[2:0];
                default:         ;
            endcase
        end
    end

    // start vector, loaded one entry per word
    always_ff @(posedge clk)
    begin
        if (in_accept && command == CMD_LOAD_VECTOR && 32'(row_index) < MAX_STATES)
        begin
            vec_reg[IW'(row_index)] <= entry_value;
        end
    end

    // run control: exponent, bank pointers, result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_reg        <= '0;
            n_m1_reg     <= '0;
            acc_id_reg   <= 1'b1;
            acc_bank_reg <= BANK_ONE;
            sq_bank_reg  <= BANK_TRANS;
            kind_sq_reg  <= 1'b0;
            result_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept && command == CMD_RUN)
                    begin
                        e_reg        <= step_count_reg;
                        acc_id_reg   <= 1'b1;
                        acc_bank_reg <= BANK_ONE;
                        sq_bank_reg  <= BANK_TRANS;
                        // zero counts as one, above the store size clamps
                        if (state_count_reg == '0)
                        begin
                            n_m1_reg <= '0;
                        end
                        else if (32'(state_count_reg) > MAX_STATES)
                        begin
                            n_m1_reg <= IW'(MAX_STATES - 1);
                        end
                        else
                        begin
                            n_m1_reg <= IW'(state_count_reg - 4'd1);
                        end
                    end
                end
                ST_STEP:
                begin
                    // first odd bit: identity times square is the square itself
                    if (e_reg != '0 && e_reg[0] && acc_id_reg)
                    begin
                        acc_bank_reg <= sq_bank_reg;
                        acc_id_reg   <= 1'b0;
                    end
                    kind_sq_reg <= 1'b0;
                end
                ST_SHIFT:
                begin
                    e_reg       <= e_reg >> 1;
                    kind_sq_reg <= 1'b1;
                end
                ST_WAIT:
                begin
                    if (pipe_empty)
                    begin
                        if (kind_sq_reg)
                        begin
                            sq_bank_reg <= dst_bank_reg;
                        end
                        else
                        begin
                            acc_bank_reg <= dst_bank_reg;
                        end
                    end
                end
                ST_FIN:
                begin
                    if (q_out_of_range)
                    begin
                        result_reg <= '0;
                    end
                    else if (acc_id_reg)
                    begin
                        result_reg <= vec_reg[q_idx];
                    end
                end
                ST_FWAIT:
                begin
                    if (s2_valid_reg && s2_last_reg)
                    begin
                        result_reg <= sum_sat;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // address generator, walks i, j, k with k innermost
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_active_reg <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            a_bank_reg     <= BANK_TRANS;
            b_bank_reg     <= BANK_TRANS;
            dst_bank_reg   <= BANK_ONE;
            op_final_reg   <= 1'b0;
        end
        else if (start_op)
        begin
            gen_active_reg <= 1'b1;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            a_bank_reg     <= op_a_bank;
            b_bank_reg     <= op_b_bank;
            dst_bank_reg   <= free_bank;
            op_final_reg   <= op_final;
        end
        else if (gen_active_reg)
        begin
            if (k_reg == n_m1_reg)
            begin
                k_reg <= '0;
                if (j_reg == lim)
                begin
                    j_reg <= '0;
                    if (i_reg == lim)
                    begin
                        gen_active_reg <= 1'b0;
                    end
                    else
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                else
                begin
                    j_reg <= j_reg + 1'b1;
                end
            end
            else
            begin
                k_reg <= k_reg + 1'b1;
            end
        end
    end

    // final pass reads the column at the query state, k walks the rows
    assign ram_raddr_a = {a_bank_reg, i_reg, k_reg};
    assign ram_raddr_b = {b_bank_reg, k_reg, op_final_reg ? q_idx : j_reg};

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= gen_active_reg;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    assign opa = op_final_reg ? s1_vec_reg : ram_rdata_a;

    // multiply-accumulate datapath
    always_ff @(posedge clk)
    begin
        s1_first_reg <= (k_reg == '0);
        s1_last_reg  <= (k_reg == n_m1_reg);
        s1_i_reg     <= i_reg;
        s1_j_reg     <= j_reg;
        s1_vec_reg   <= vec_reg[k_reg];
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_i_reg     <= s1_i_reg;
        s2_j_reg     <= s1_j_reg;
        prod_reg     <= 18'((34'(opa) * 34'(ram_rdata_b)) >> FRAC_W);
        if (s2_valid_reg)
        begin
            macc_reg <= sum_sat;
        end
    end

    // products are non-negative, so clamping every step equals clamping at the end
    assign sum     = (s2_first_reg ? 19'd0 : 19'(macc_reg)) + 19'(prod_reg);
    assign sum_sat = (sum > 19'(VAL_MAX)) ? VAL_MAX : sum[16:0];

    // ram write: matrix loads when idle, product entries during a run
    assign load_matrix = in_accept && command == CMD_LOAD_MATRIX
                         && 32'(row_index) < MAX_STATES && 32'(col_index) < MAX_STATES;

    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            ram_we    = load_matrix;
            ram_waddr = {BANK_TRANS, IW'(row_index), IW'(col_index)};
            ram_wdata = entry_value;
        end
        else
        begin
            ram_we    = s2_valid_reg && s2_last_reg && !op_final_reg;
            ram_waddr = {dst_bank_reg, s2_i_reg, s2_j_reg};
            ram_wdata = sum_sat;
        end
    end

    mcnsp_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            prob_reg      <= '0;
        end
        else if (state_reg == ST_DONE && (!out_valid_reg || !out_stall))
        begin
            out_valid_reg <= 1'b1;
            prob_reg      <= result_reg;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // checks
    `MCNSP_ASSERT_IMPLY(a_trans_kept, ram_we && state_reg != ST_IDLE, ram_waddr[AW-1 -: 2] != BANK_TRANS)
    `MCNSP_ASSERT_IMPLY(a_dst_free, gen_active_reg && !op_final_reg, dst_bank_reg != a_bank_reg && dst_bank_reg != b_bank_reg)
    `MCNSP_ASSERT_NEXT(a_shift_halves, state_reg == ST_SHIFT, e_reg == ($past(e_reg) >> 1))
    `MCNSP_ASSERT_IMPLY(a_result_from_done, out_valid_reg && !$past(out_valid_reg), $past(state_reg) == ST_DONE)

endmodule

@@ sim/tb_markov_chain_n_step_probability.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_markov_chain_n_step_probability
// self-checking bench: loads random chains, runs matrix powers under bursty
// input and stalled output, and compares each probability with a local
// square-and-multiply predictor
// ---------------------------------------------------------------------------
module tb_markov_chain_n_step_probability
    import mcnsp_pkg::*;
();

    typedef logic [16:0] mat_t [8][8];

    typedef struct {
        logic [1:0]  cmd;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [16:0] val;
    } chain_word_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  command;
    logic [2:0]  row_index;
    logic [2:0]  col_index;
    logic [16:0] entry_value;
    logic        out_valid;
    logic        out_stall;
    logic [16:0] probability;

    markov_chain_n_step_probability DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .row_index   (row_index),
        .col_index   (col_index),
        .entry_value (entry_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .probability (probability)
    );

    // predictor copy of the block's stores and registers
    mat_t        chain_m;
    logic [16:0] start_v [8];
    logic [3:0]  n_reg;
    logic [15:0] steps_reg;
    logic [2:0]  query_reg;

    chain_word_t word_q [$];     // words waiting for the driver
    logic [16:0] prob_q [$];     // probabilities still owed by the block
    chain_word_t held;           // word currently offered
    int          gap_left;
    int          burst_left;
    int          mismatches;
    int          results_seen;
    int          hold_left;
    int          stall_mode;
    int          cycles;

    // truncating fixed point product of two matrices, saturating sums
    function automatic void mat_product(input mat_t a, input mat_t b, input int n,
                                        output mat_t p);
        logic [63:0] acc;
        p = a;
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
            begin
                acc = 0;
                for (int k = 0; k < n; k++)
                    acc += (64'(a[i][k]) * 64'(b[k][j])) >> FRAC_W;
                p[i][j] = (acc > 64'(VAL_MAX)) ? VAL_MAX : acc[16:0];
            end
    endfunction

    // probability at the query state after the configured number of steps
    function automatic logic [16:0] n_step_prob();
        mat_t        pw;
        mat_t        sq;
        mat_t        tmp;
        int          n;
        int          e;
        logic [63:0] acc;
        n = (n_reg == 0) ? 1 : (n_reg > 8) ? 8 : int'(n_reg);
        for (int i = 0; i < 8; i++)
            for (int j = 0; j < 8; j++)
                pw[i][j] = (i == j) ? 17'h10000 : 17'h0;
        sq = chain_m;
        e = steps_reg;
        while (e > 0)
        begin
            if (e[0])
            begin
                mat_product(pw, sq, n, tmp);
                pw = tmp;
            end
            e = e >> 1;
            if (e > 0)
            begin
                mat_product(sq, sq, n, tmp);
                sq = tmp;
            end
        end
        if (int'(query_reg) >= n)
            return 17'h0;
        acc = 0;
        for (int i = 0; i < n; i++)
            acc += (64'(start_v[i]) * 64'(pw[i][query_reg])) >> FRAC_W;
        return (acc > 64'(VAL_MAX)) ? VAL_MAX : acc[16:0];
    endfunction

    // clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // cycle limit, far above the slowest correct run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 20000000)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // driver: bursts of words with random gaps, payload held while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            command     <= CMD_LOAD_MATRIX;
            row_index   <= 3'd0;
            col_index   <= 3'd0;
            entry_value <= 17'd0;
            gap_left    = 0;
            burst_left  = 8;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                // accepted word updates the predictor
                case (held.cmd)
                    CMD_LOAD_MATRIX: chain_m[held.row][held.col] = held.val;
                    CMD_LOAD_VECTOR: start_v[held.row] = held.val;
                    CMD_RUN:         prob_q.push_back(n_step_prob());
                    default: ;
                endcase
            end
            if (in_valid && in_stall)
                ; // hold the stalled word
            else if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (word_q.size() > 0)
            begin
                held = word_q.pop_front();
                in_valid    <= 1'b1;
                command     <= held.cmd;
                row_index   <= held.row;
                col_index   <= held.col;
                entry_value <= held.val;
                burst_left = burst_left - 1;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 30);
                    // some bursts run back to back
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor: checks each result word and drives the stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall    <= 1'b0;
            mismatches   = 0;
            results_seen = 0;
            hold_left    = 0;
            stall_mode   = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen = results_seen + 1;
                if (prob_q.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected result word %h", probability);
                end
                else if (probability !== prob_q[0])
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("probability mismatch: expected %h got %h",
                                 prob_q[0], probability);
                    void'(prob_q.pop_front());
                end
                else
                    void'(prob_q.pop_front());
                // one long hold-off so the block backs up on its input
                if (results_seen == 40)
                    hold_left = 3000;
            end
            if (cycles % 64 == 0)
                stall_mode = $urandom_range(0, 2);
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_stall <= 1'b1;
            end
            else if (stall_mode == 0)
                out_stall <= 1'b0;
            else if (stall_mode == 1)
                out_stall <= ($urandom_range(0, 9) < 3);
            else
                out_stall <= ($urandom_range(0, 9) < 8);
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_STATE_COUNT: n_reg     = data[3:0];
            REG_STEP_COUNT:  steps_reg = data;
            REG_QUERY_STATE: query_reg = data[2:0];
            default: ;
        endcase
    endtask

    task automatic set_chain(input int n, input int steps, input int q);
        write_reg(REG_STATE_COUNT, 16'(n));
        write_reg(REG_STEP_COUNT, 16'(steps));
        write_reg(REG_QUERY_STATE, 16'(q));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // sender pause until the block owes nothing, then a settle margin
    task automatic drain();
        while (word_q.size() > 0 || in_valid || prob_q.size() > 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic add_word(input logic [1:0] c, input int r, input int k, input int v);
        chain_word_t w;
        w.cmd = c;
        w.row = 3'(r);
        w.col = 3'(k);
        w.val = 17'(v);
        word_q.push_back(w);
    endtask

    initial
    begin
        int n;
        int steps;
        int cap;
        int pick;
        cycles    = 0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_STATE_COUNT;
        cfg_data  = 16'd0;
        n_reg     = 4'd8;
        steps_reg = 16'd1;
        query_reg = 3'd0;
        for (int i = 0; i < 8; i++)
        begin
            start_v[i] = 0;
            for (int j = 0; j < 8; j++)
                chain_m[i][j] = 0;
        end
        repeat (12) @(posedge clk);
        rst_n = 1'b1;

        // fill every store entry first so no run reads an unwritten one
        for (int i = 0; i < 8; i++)
        begin
            add_word(CMD_LOAD_VECTOR, i, $urandom_range(0, 7), $urandom_range(0, 16384));
            for (int j = 0; j < 8; j++)
                add_word(CMD_LOAD_MATRIX, i, j, $urandom_range(0, 8192));
        end
        add_word(CMD_RUN, 0, 0, 0);          // reset settings
        drain();

        // directed: zero steps, clamped counts, query past the states, extremes
        set_chain(3, 0, 2);
        add_word(CMD_RUN, 7, 7, 131071);
        add_word(2'd3, 7, 7, 131071);        // unused command, no result
        drain();
        set_chain(0, 5, 0);                  // zero count acts as one state
        add_word(CMD_LOAD_MATRIX, 0, 0, 131071);
        add_word(CMD_LOAD_VECTOR, 0, 0, 131071);
        add_word(CMD_RUN, 0, 0, 0);
        drain();
        set_chain(15, 3, 7);                 // count above the limit
        add_word(CMD_LOAD_MATRIX, 7, 7, 0);
        add_word(CMD_RUN, 0, 0, 0);
        drain();
        set_chain(2, 65535, 1);
        add_word(CMD_LOAD_MATRIX, 0, 1, 65536);
        add_word(CMD_LOAD_MATRIX, 1, 0, 32768);
        add_word(CMD_RUN, 0, 0, 0);
        drain();
        set_chain(4, 9, 6);                  // query beyond the states in use
        add_word(CMD_RUN, 0, 0, 0);
        drain();
        set_chain(8, 2, 5);
        add_word(CMD_LOAD_MATRIX, 5, 3, 131071);
        add_word(CMD_RUN, 0, 0, 0);
        drain();

        // random phases, each with settings written while idle
        for (int ph = 0; ph < 22; ph++)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                n = $urandom_range(0, 15);
            else if (pick < 3)
                n = $urandom_range(5, 8);
            else
                n = $urandom_range(1, 4);
            if (n >= 5 || n == 0)
                steps = $urandom_range(0, 12);
            else if ($urandom_range(0, 4) == 0)
                steps = (n <= 2) ? $urandom_range(0, 65535) : $urandom_range(0, 1023);
            else
                steps = $urandom_range(0, 40);
            set_chain(n, steps, $urandom_range(0, 7));
            cap = (n == 0) ? 65536 : 65536 / ((n > 8) ? 8 : n) + 4096;
            for (int k = 0; k < 75; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    add_word(CMD_LOAD_MATRIX, $urandom_range(0, 7), $urandom_range(0, 7),
                             ($urandom_range(0, 9) == 0) ? $urandom_range(0, 131071)
                                                         : $urandom_range(0, cap));
                else if (pick < 75)
                    add_word(CMD_LOAD_VECTOR, $urandom_range(0, 7), $urandom_range(0, 7),
                             ($urandom_range(0, 9) == 0) ? $urandom_range(0, 131071)
                                                         : $urandom_range(0, cap));
                else if (pick < 95)
                    add_word(CMD_RUN, $urandom_range(0, 7), $urandom_range(0, 7),
                             $urandom_range(0, 131071));
                else
                    add_word(2'd3, $urandom_range(0, 7), $urandom_range(0, 7),
                             $urandom_range(0, 131071));
            end
            drain();
        end

        repeat (50) @(posedge clk);
        if (mismatches == 0 && prob_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/mcnsp_pkg.sv
rtl/mcnsp_ram.sv
rtl/markov_chain_n_step_probability.sv
sim/tb_markov_chain_n_step_probability.sv
